// ----- rtl/dcma_pkg.sv -----
`default_nettype none

package dcma_pkg;

  // Sizes
  localparam int MAX_JOINTS  = 16;
  localparam int MAX_WINDOW  = 32;
  localparam int MIN_WINDOW  = 3;
  localparam int SAMPLE_W    = 16;
  localparam int JOINT_W     = 4;
  localparam int WIN_W       = 6;
  localparam int POS_W       = 5;
  localparam int SUM_W       = 21;
  localparam int HIST_DEPTH  = MAX_JOINTS * MAX_WINDOW;
  localparam int HIST_ADDR_W = JOINT_W + POS_W;
  localparam int HIST_DATA_W = 2 * SAMPLE_W;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;
  localparam int DIV_STEPS   = SUM_W;
  localparam int DIV_CNT_W   = 5;

  // Register map
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;
  localparam logic REG_IDX_WINDOW = 1'b0;

  // Sequencer states of the back end
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RMW,
    ST_DIV
  } state_t;

  // One queued sample pair
  typedef struct packed {
    logic [JOINT_W-1:0]         joint;
    logic signed [SAMPLE_W-1:0] ag;
    logic signed [SAMPLE_W-1:0] an;
  } item_t;

  // One averaged result
  typedef struct packed {
    logic [JOINT_W-1:0]         joint;
    logic signed [SAMPLE_W-1:0] ag_mean;
    logic signed [SAMPLE_W-1:0] an_mean;
  } result_t;

  // Queue status toward the top level
  typedef struct packed {
    logic [QCNT_W-1:0] count;
    logic              full;
  } queue_stat_t;

endpackage

`default_nettype wire

// ----- rtl/dcma_queue.sv -----
`default_nettype none

module dcma_queue
  import dcma_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  input  wire item_t       push_item,
  input  wire logic        pop,
  output logic             q_valid,
  output item_t            q_item,
  output queue_stat_t      stat
);

  item_t             entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  // Push only when there is room, pop only when there is data
  assign do_push = push && (count_r != QCNT_W'(QUEUE_DEPTH));
  assign do_pop  = pop && (count_r != '0);

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!do_push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Payload storage, no reset
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  assign q_valid    = (count_r != '0);
  assign q_item     = entry_r[rd_ptr_r];
  assign stat.count = count_r;
  assign stat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));

endmodule

`default_nettype wire

// ----- rtl/dcma_div.sv -----
`default_nettype none

module dcma_div
  import dcma_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     start,
  input  wire logic signed [SUM_W-1:0]  dividend,
  input  wire logic [WIN_W-1:0]         divisor,
  output logic                          done,
  output logic signed [SAMPLE_W-1:0]    quotient
);

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [SUM_W-1:0]     dq_r, dq_nxt;
  logic [POS_W-1:0]     rem_r, rem_nxt;
  logic                 neg_r;
  logic [WIN_W-1:0]     dvs_r;
  logic [WIN_W-1:0]     rem_sh;
  logic [WIN_W-1:0]     rem_diff;
  logic                 ge;
  logic [SUM_W-1:0]     mag;
  logic [SUM_W-1:0]     q_signed;

  // Magnitude of the dividend; -2^20 still fits unsigned
  assign mag = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;

  // One restoring step per cycle while busy
  always_comb begin
    rem_sh   = {rem_r, dq_r[SUM_W-1]};
    rem_diff = rem_sh - dvs_r;
    ge       = (rem_sh >= dvs_r);
    rem_nxt  = ge ? rem_diff[POS_W-1:0] : rem_sh[POS_W-1:0];
    dq_nxt   = {dq_r[SUM_W-2:0], ge};
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= DIV_CNT_W'(DIV_STEPS - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dq_r  <= mag;
      rem_r <= '0;
      neg_r <= dividend[SUM_W-1];
      dvs_r <= divisor;
    end else if (busy_r) begin
      dq_r  <= dq_nxt;
      rem_r <= rem_nxt;
    end
  end

  // Truncation toward zero: divide the magnitude, then restore the sign
  assign q_signed = neg_r ? (~dq_r + 1'b1) : dq_r;
  assign quotient = q_signed[SAMPLE_W-1:0];
  assign done     = done_r;

endmodule

`default_nettype wire

// ----- rtl/dcma_core.sv -----
`default_nettype none

module dcma_core
  import dcma_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              clear,
  input  wire logic [WIN_W-1:0]  window,
  input  wire logic              q_valid,
  input  wire item_t             q_item,
  output logic                   q_pop,
  output logic                   res_valid,
  output result_t                res,
  input  wire logic              res_take
);

  state_t state_r, state_nxt;

  // Per-joint state
  logic signed [SUM_W-1:0] sum_ag_r [MAX_JOINTS];
  logic signed [SUM_W-1:0] sum_an_r [MAX_JOINTS];
  logic [POS_W-1:0]        wpos_r   [MAX_JOINTS];
  logic [WIN_W-1:0]        fill_r   [MAX_JOINTS];

  // History memory, both channels side by side
  logic [HIST_DATA_W-1:0]  hist_mem [HIST_DEPTH];
  logic [HIST_DATA_W-1:0]  rd_data_r;
  logic [HIST_ADDR_W-1:0]  rd_addr;
  logic [HIST_ADDR_W-1:0]  wr_addr;
  logic                    hist_we;

  // Item being worked on
  logic [JOINT_W-1:0]         cur_joint_r;
  logic signed [SAMPLE_W-1:0] cur_ag_r;
  logic signed [SAMPLE_W-1:0] cur_an_r;
  logic [POS_W-1:0]           cur_pos_r;

  logic [POS_W-1:0]           head_pos;
  logic                       slot_valid;
  logic signed [SAMPLE_W-1:0] old_ag;
  logic signed [SAMPLE_W-1:0] old_an;
  logic signed [SUM_W-1:0]    sum_ag_new;
  logic signed [SUM_W-1:0]    sum_an_new;
  logic [WIN_W-1:0]           pos_inc;
  logic [POS_W-1:0]           pos_next;
  logic                       div_start;
  logic                       ag_done, an_done;
  logic signed [SAMPLE_W-1:0] ag_q, an_q;
  logic                       do_pop;

  // Slot of the oldest sample for the joint at the queue head
  always_comb begin
    head_pos = wpos_r[q_item.joint];
    if ({1'b0, head_pos} >= window) begin
      head_pos = '0;
    end
  end

  assign rd_addr = {q_item.joint, head_pos};
  assign wr_addr = {cur_joint_r, cur_pos_r};

  // Slots at or past the fill count were not written since the last clear
  assign slot_valid = ({1'b0, cur_pos_r} < fill_r[cur_joint_r]);
  assign old_ag     = slot_valid ? rd_data_r[HIST_DATA_W-1:SAMPLE_W] : '0;
  assign old_an     = slot_valid ? rd_data_r[SAMPLE_W-1:0] : '0;

  // Running sums: add the new sample, drop the one it replaces
  assign sum_ag_new = sum_ag_r[cur_joint_r]
                    + {{(SUM_W-SAMPLE_W){cur_ag_r[SAMPLE_W-1]}}, cur_ag_r}
                    - {{(SUM_W-SAMPLE_W){old_ag[SAMPLE_W-1]}}, old_ag};
  assign sum_an_new = sum_an_r[cur_joint_r]
                    + {{(SUM_W-SAMPLE_W){cur_an_r[SAMPLE_W-1]}}, cur_an_r}
                    - {{(SUM_W-SAMPLE_W){old_an[SAMPLE_W-1]}}, old_an};

  // Circular advance of the write slot
  assign pos_inc  = {1'b0, cur_pos_r} + 1'b1;
  assign pos_next = (pos_inc >= window) ? '0 : pos_inc[POS_W-1:0];

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          state_nxt = ST_RMW;
        end
      end
      ST_RMW: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    do_pop    = 1'b0;
    hist_we   = 1'b0;
    div_start = 1'b0;
    res_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        do_pop = q_valid;
      end
      ST_RMW: begin
        hist_we   = 1'b1;
        div_start = 1'b1;
      end
      ST_DIV: begin
        res_valid = ag_done && an_done;
      end
      default: begin
        do_pop = 1'b0;
      end
    endcase
  end

  assign q_pop = do_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Capture the item as it leaves the queue
  always_ff @(posedge clk) begin
    if (do_pop) begin
      cur_joint_r <= q_item.joint;
      cur_ag_r    <= q_item.ag;
      cur_an_r    <= q_item.an;
      cur_pos_r   <= head_pos;
    end
  end

  // History memory: write in the update cycle, registered read
  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[wr_addr] <= {cur_ag_r, cur_an_r};
    end
    rd_data_r <= hist_mem[rd_addr];
  end

  // Per-joint sums, slots and fill counts; a window write clears them all
  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      for (int j = 0; j < MAX_JOINTS; j++) begin
        sum_ag_r[j] <= '0;
        sum_an_r[j] <= '0;
        wpos_r[j]   <= '0;
        fill_r[j]   <= '0;
      end
    end else if (hist_we) begin
      sum_ag_r[cur_joint_r] <= sum_ag_new;
      sum_an_r[cur_joint_r] <= sum_an_new;
      wpos_r[cur_joint_r]   <= pos_next;
      if (fill_r[cur_joint_r] < window) begin
        fill_r[cur_joint_r] <= fill_r[cur_joint_r] + 1'b1;
      end
    end
  end

  // One divider lane per channel
  dcma_div u_div_ag (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_ag_new),
    .divisor  (window),
    .done     (ag_done),
    .quotient (ag_q)
  );

  dcma_div u_div_an (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_an_new),
    .divisor  (window),
    .done     (an_done),
    .quotient (an_q)
  );

  assign res.joint   = cur_joint_r;
  assign res.ag_mean = ag_q;
  assign res.an_mean = an_q;

endmodule

`default_nettype wire

// ----- rtl/dual_channel_moving_average.sv -----
`default_nettype none

// Per-joint boxcar mean on two channels. Each input transfer carries a joint
// index and one agonist and one antagonist sample; the block replaces the
// oldest sample in that joint's history, keeps a running sum, and returns
// sum / window_length for both channels, truncated toward zero. A two-entry
// input queue takes transfers while the back end works, and a result
// register holds the last mean until it is taken. Each item passes through
// the back end in order: the idle state pops the queue and reads the history
// memory, the update state updates the sums and writes the memory, the
// bit-per-cycle dividers run, and the result register is loaded once the
// result side can take it; only then is the next item popped. Writing
// window_length (APB addresses 0 to 3, clamped to 3..32) clears every
// history at once; it is meant to be written only while the block is idle.

module dual_channel_moving_average
  import dcma_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  // Input channel
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [JOINT_W-1:0]       in_joint,
  input  wire logic signed [SAMPLE_W-1:0] in_agonist_sample,
  input  wire logic signed [SAMPLE_W-1:0] in_antagonist_sample,
  // Result channel
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [JOINT_W-1:0]            out_joint_out,
  output logic signed [SAMPLE_W-1:0]    out_agonist_mean,
  output logic signed [SAMPLE_W-1:0]    out_antagonist_mean,
  // Configuration port
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic [APB_ADDR_W-1:0]    paddr,
  input  wire logic [APB_DATA_W-1:0]    pwdata,
  output logic [APB_DATA_W-1:0]         prdata,
  output logic                          pready
);

  logic [WIN_W-1:0] window_r, window_nxt;
  logic             cfg_wr;
  logic [WIN_W-1:0] wr_val;

  item_t            push_item;
  logic             q_valid;
  item_t            q_item;
  logic             q_pop;
  queue_stat_t      q_stat;

  logic             res_valid;
  result_t          res;
  logic             res_take;

  logic                       out_valid_r;
  logic [JOINT_W-1:0]         out_joint_r;
  logic signed [SAMPLE_W-1:0] out_ag_r;
  logic signed [SAMPLE_W-1:0] out_an_r;

  // Window register write with clamping
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
               && (paddr[APB_ADDR_W-1] == REG_IDX_WINDOW);
  assign wr_val = pwdata[WIN_W-1:0];

  always_comb begin
    window_nxt = wr_val;
    if (wr_val < WIN_W'(MIN_WINDOW)) begin
      window_nxt = WIN_W'(MIN_WINDOW);
    end else if (wr_val > WIN_W'(MAX_WINDOW)) begin
      window_nxt = WIN_W'(MAX_WINDOW);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= WIN_W'(MIN_WINDOW);
    end else if (cfg_wr) begin
      window_r <= window_nxt;
    end
  end

  // Register readback
  always_comb begin
    prdata = '0;
    if (paddr[APB_ADDR_W-1] == REG_IDX_WINDOW) begin
      prdata = {{(APB_DATA_W-WIN_W){1'b0}}, window_r};
    end
  end

  // Front end: input queue
  assign push_item.joint = in_joint;
  assign push_item.ag    = in_agonist_sample;
  assign push_item.an    = in_antagonist_sample;
  assign in_stall        = q_stat.full;

  dcma_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_valid),
    .push_item (push_item),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .stat      (q_stat)
  );

  // Back end: history update and division
  dcma_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (cfg_wr),
    .window    (window_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  // Result register
  assign res_take = res_valid && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_joint_r <= res.joint;
      out_ag_r    <= res.ag_mean;
      out_an_r    <= res.an_mean;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_joint_out       = out_joint_r;
  assign out_agonist_mean    = out_ag_r;
  assign out_antagonist_mean = out_an_r;

`ifndef ASSERT_OFF
  // Window stays inside its legal range
  a_window_range: assert property (@(posedge clk) disable iff (!rst_n)
    (window_r >= WIN_W'(MIN_WINDOW)) && (window_r <= WIN_W'(MAX_WINDOW)))
    else $error("window_length out of range");

  // A result is only loaded when the result register can take it
  a_res_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_take |-> (!out_valid_r || !out_stall))
    else $error("result loaded over a pending transfer");

  // A loaded result shows up on the output next cycle
  a_res_shown: assert property (@(posedge clk) disable iff (!rst_n)
    res_take |=> out_valid_r)
    else $error("loaded result not presented");

  // Queue never holds more than its depth
  a_queue_depth: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= QCNT_W'(QUEUE_DEPTH))
    else $error("input queue overflow");
`endif

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import dcma_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int DRAIN_CYCLES = 40;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 200;
  localparam int REPORT_MAX   = 10;

  // Register addresses: window_length, and one address with no register
  localparam logic [APB_ADDR_W-1:0] ADDR_WINDOW = {REG_IDX_WINDOW, 2'b00};
  localparam logic [APB_ADDR_W-1:0] ADDR_UNUSED = {~REG_IDX_WINDOW, 2'b00};

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t                  kind;
    logic [APB_ADDR_W-1:0]      addr;
    logic [APB_DATA_W-1:0]      data;
    logic [JOINT_W-1:0]         joint;
    logic signed [SAMPLE_W-1:0] ag;
    logic signed [SAMPLE_W-1:0] an;
    bit                         typed;
    logic signed [SAMPLE_W-1:0] ag_mean;
    logic signed [SAMPLE_W-1:0] an_mean;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [JOINT_W-1:0] in_joint;
  logic signed [SAMPLE_W-1:0] in_agonist_sample;
  logic signed [SAMPLE_W-1:0] in_antagonist_sample;
  logic out_valid;
  logic out_stall;
  logic [JOINT_W-1:0] out_joint_out;
  logic signed [SAMPLE_W-1:0] out_agonist_mean;
  logic signed [SAMPLE_W-1:0] out_antagonist_mean;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  // Filter state as the testbench sees it
  logic signed [SAMPLE_W-1:0] ag_hist [MAX_JOINTS][MAX_WINDOW];
  logic signed [SAMPLE_W-1:0] an_hist [MAX_JOINTS][MAX_WINDOW];
  int ag_sum [MAX_JOINTS];
  int an_sum [MAX_JOINTS];
  int unsigned wr_pos [MAX_JOINTS];
  int unsigned win_len;

  result_t mean_q [$];
  row_t dir_rows [$];
  int errors;
  int cycles;
  bit idle_on;
  int gap_pct;
  int stall_pct;

  dual_channel_moving_average uut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_joint             (in_joint),
    .in_agonist_sample    (in_agonist_sample),
    .in_antagonist_sample (in_antagonist_sample),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_joint_out        (out_joint_out),
    .out_agonist_mean     (out_agonist_mean),
    .out_antagonist_mean  (out_antagonist_mean),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  always #5 clk = ~clk;

  // Clear every history, sum and write position
  function automatic void clear_filter();
    for (int j = 0; j < MAX_JOINTS; j++) begin
      for (int k = 0; k < MAX_WINDOW; k++) begin
        ag_hist[j][k] = '0;
        an_hist[j][k] = '0;
      end
      ag_sum[j] = 0;
      an_sum[j] = 0;
      wr_pos[j] = 0;
    end
  endfunction

  // Register write as the block applies it: clamp to 3..32, then clear
  function automatic void apply_window(input logic [APB_ADDR_W-1:0] a,
                                       input logic [APB_DATA_W-1:0] d);
    int unsigned v;
    if (a != ADDR_WINDOW) return;
    v = d[WIN_W-1:0];
    if (v < MIN_WINDOW) v = MIN_WINDOW;
    if (v > MAX_WINDOW) v = MAX_WINDOW;
    win_len = v;
    clear_filter();
  endfunction

  // Push one sample pair into the joint's window and return both means
  function automatic result_t average_pair(input logic [JOINT_W-1:0] j,
                                           input logic signed [SAMPLE_W-1:0] ag,
                                           input logic signed [SAMPLE_W-1:0] an);
    int unsigned pos;
    int ag_div;
    int an_div;
    result_t r;
    pos = wr_pos[j];
    if (pos >= win_len) pos = 0;
    ag_sum[j] += int'(ag) - int'(ag_hist[j][pos]);
    an_sum[j] += int'(an) - int'(an_hist[j][pos]);
    ag_hist[j][pos] = ag;
    an_hist[j][pos] = an;
    pos++;
    if (pos >= win_len) pos = 0;
    wr_pos[j] = pos;
    // signed int division truncates toward zero
    ag_div = ag_sum[j] / int'(win_len);
    an_div = an_sum[j] / int'(win_len);
    r.joint   = j;
    r.ag_mean = ag_div[SAMPLE_W-1:0];
    r.an_mean = an_div[SAMPLE_W-1:0];
    return r;
  endfunction

  function automatic row_t item_row(input logic [JOINT_W-1:0] j,
                                    input logic signed [SAMPLE_W-1:0] ag,
                                    input logic signed [SAMPLE_W-1:0] an,
                                    input bit typed,
                                    input logic signed [SAMPLE_W-1:0] eag,
                                    input logic signed [SAMPLE_W-1:0] ean);
    row_t r;
    r.kind = ROW_ITEM;
    r.addr = '0;
    r.data = '0;
    r.joint = j;
    r.ag = ag;
    r.an = an;
    r.typed = typed;
    r.ag_mean = eag;
    r.an_mean = ean;
    return r;
  endfunction

  function automatic row_t cfg_row(input logic [APB_ADDR_W-1:0] a,
                                   input logic [APB_DATA_W-1:0] d);
    row_t r;
    r = item_row('0, '0, '0, 1'b0, '0, '0);
    r.kind = ROW_CFG;
    r.addr = a;
    r.data = d;
    return r;
  endfunction

  // Random sample with the extremes weighted in
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return '0;
      3: return '1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // One input transfer, with an optional gap before it
  task automatic send_item(input logic [JOINT_W-1:0] j,
                           input logic signed [SAMPLE_W-1:0] ag,
                           input logic signed [SAMPLE_W-1:0] an,
                           input bit typed,
                           input logic signed [SAMPLE_W-1:0] eag,
                           input logic signed [SAMPLE_W-1:0] ean);
    result_t r;
    if (idle_on && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_joint <= j;
    in_agonist_sample <= ag;
    in_antagonist_sample <= an;
    do @(posedge clk); while (in_stall);
    r = average_pair(j, ag, an);
    if (typed) begin
      r.ag_mean = eag;
      r.an_mean = ean;
    end
    mean_q.push_back(r);
  endtask

  // Register write once the block is idle, then read window_length back
  task automatic write_window(input logic [APB_ADDR_W-1:0] a,
                              input logic [APB_DATA_W-1:0] d);
    while (mean_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= a;
    pwdata <= d;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    apply_window(a, d);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    psel <= 1'b1;
    paddr <= ADDR_WINDOW;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== APB_DATA_W'(win_len)) begin
      errors++;
      if (errors <= REPORT_MAX)
        $display("readback mismatch: window exp %0d got %0d", win_len, prdata);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Cycle counter and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Result side back-pressure in random bursts
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (idle_on && rst_n && $urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Compare each result transfer with the oldest expected mean
  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (mean_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("unexpected result: joint %0d means %0d %0d",
                   out_joint_out, out_agonist_mean, out_antagonist_mean);
      end else begin
        e = mean_q.pop_front();
        if (out_joint_out !== e.joint || out_agonist_mean !== e.ag_mean ||
            out_antagonist_mean !== e.an_mean) begin
          errors++;
          if (errors <= REPORT_MAX)
            $display("result mismatch: exp joint %0d ag %0d an %0d, got %0d %0d %0d",
                     e.joint, e.ag_mean, e.an_mean,
                     out_joint_out, out_agonist_mean, out_antagonist_mean);
        end
      end
    end
  end

  initial begin
    logic [APB_DATA_W-1:0] wdata;
    cycles = 0;
    errors = 0;
    idle_on = 1'b1;
    gap_pct = 10;
    stall_pct = 10;
    win_len = MIN_WINDOW;
    clear_filter();
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_joint <= '0;
    in_agonist_sample <= '0;
    in_antagonist_sample <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;

    // Directed rows: reset window of 3, extremes, clamping, truncation
    dir_rows.push_back(item_row(4'd0, 16'sh7FFF, 16'sh8000, 1'b1, 16'sd10922, -16'sd10922));
    dir_rows.push_back(item_row(4'd0, 16'sh7FFF, 16'sh8000, 1'b1, 16'sd21844, -16'sd21845));
    dir_rows.push_back(item_row(4'd0, 16'sh7FFF, 16'sh8000, 1'b1, 16'sh7FFF, 16'sh8000));
    dir_rows.push_back(item_row(4'd0, -16'sd1, 16'sd1, 1'b1, 16'sd21844, -16'sd21845));
    dir_rows.push_back(item_row(4'd15, 16'sh8000, 16'sh7FFF, 1'b1, -16'sd10922, 16'sd10922));
    dir_rows.push_back(item_row(4'd5, 16'shAAAA, 16'sh5555, 1'b0, '0, '0));
    dir_rows.push_back(item_row(4'd10, 16'sh5555, 16'shAAAA, 1'b0, '0, '0));
    // short window write clamps to 3 and clears
    dir_rows.push_back(cfg_row(ADDR_WINDOW, 32'd0));
    dir_rows.push_back(item_row(4'd0, 16'sd3, -16'sd3, 1'b1, 16'sd1, -16'sd1));
    dir_rows.push_back(item_row(4'd0, -16'sd2, 16'sd0, 1'b0, '0, '0));
    // long window write clamps to 32
    dir_rows.push_back(cfg_row(ADDR_WINDOW, 32'd63));
    dir_rows.push_back(item_row(4'd0, 16'sh7FFF, 16'sh8000, 1'b1, 16'sd1023, -16'sd1024));
    // upper data bits are dropped: window of 4; negative mean truncates toward zero
    dir_rows.push_back(cfg_row(ADDR_WINDOW, 32'hFFFF_FFC4));
    dir_rows.push_back(item_row(4'd7, -16'sd5, 16'sd7, 1'b1, -16'sd1, 16'sd1));
    // write to an address with no register changes nothing
    dir_rows.push_back(cfg_row(ADDR_UNUSED, 32'd10));
    dir_rows.push_back(item_row(4'd7, -16'sd5, 16'sd7, 1'b1, -16'sd2, 16'sd3));
    // same value again still clears the histories
    dir_rows.push_back(cfg_row(ADDR_WINDOW, 32'd4));
    dir_rows.push_back(item_row(4'd7, -16'sd5, 16'sd7, 1'b1, -16'sd1, 16'sd1));
    dir_rows.push_back(cfg_row(ADDR_WINDOW, 32'd2));
    dir_rows.push_back(item_row(4'd3, 16'sh8000, 16'sh8000, 1'b0, '0, '0));
    dir_rows.push_back(cfg_row(ADDR_WINDOW, 32'd32));
    dir_rows.push_back(item_row(4'd12, 16'sh7FFF, 16'sh7FFF, 1'b0, '0, '0));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        in_valid <= 1'b0;
        write_window(dir_rows[i].addr, dir_rows[i].data);
      end else begin
        send_item(dir_rows[i].joint, dir_rows[i].ag, dir_rows[i].an,
                  dir_rows[i].typed, dir_rows[i].ag_mean, dir_rows[i].an_mean);
      end
    end
    in_valid <= 1'b0;

    // Random phases, each under a new window setting; the last has no idling
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: wdata = 32'd32;
        1: wdata = 32'd2;
        2: wdata = 32'd3;
        3: wdata = 32'd63;
        4: wdata = $urandom_range(MIN_WINDOW, MAX_WINDOW);
        5: wdata = 32'd1;
        6: wdata = $urandom;
        default: wdata = 32'd32;
      endcase
      write_window(ADDR_WINDOW, wdata);
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 10;
        default: gap_pct = 30;
      endcase
      stall_pct = $urandom_range(0, 2) * 4;
      if (p == PHASES - 1) idle_on = 1'b0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // mostly a few joints so that windows fill and wrap
        send_item(($urandom_range(0, 3) != 0) ? JOINT_W'($urandom_range(0, 3))
                                              : JOINT_W'($urandom),
                  pick_sample(), pick_sample(), 1'b0, '0, '0);
      end
      in_valid <= 1'b0;
    end

    while (mean_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
